FILE: sv/vt4_pkg.sv
// vt4_pkg: shared constants and types for the 4x4 vertex transform
`default_nettype none

package vt4_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int VEC_BITS      = 32;
	localparam int FRAC_BITS     = 16;
	localparam int NUM_COMP      = 4;
	localparam int NUM_REGS      = 8;
	localparam int CFG_IDX_BITS  = 4;
	localparam int CFG_SEL_BITS  = $clog2(NUM_REGS);
	localparam int CFG_DATA_BITS = 64;
	localparam int HALF_BITS     = CFG_DATA_BITS / 2;

	typedef logic signed [VEC_BITS-1:0] vec_word_t;
	typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;
	typedef cfg_word_t cfg_regs_t [NUM_REGS];

	// identity matrix, column-major, two rows per register
	localparam cfg_regs_t CFG_RESET = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

endpackage

`default_nettype wire

FILE: sv/vt4_in_if.sv
// vt4_in_if: input vector channel
`default_nettype none

interface vt4_in_if;
	logic                       valid;
	logic                       ready;
	logic signed [vt4_pkg::VEC_BITS-1:0] in_x;
	logic signed [vt4_pkg::VEC_BITS-1:0] in_y;
	logic signed [vt4_pkg::VEC_BITS-1:0] in_z;
	logic signed [vt4_pkg::VEC_BITS-1:0] in_w;

	modport source (output valid, output in_x, output in_y, output in_z, output in_w,
		input ready);
	modport sink (input valid, input in_x, input in_y, input in_z, input in_w,
		output ready);
endinterface

`default_nettype wire

FILE: sv/vt4_out_if.sv
// vt4_out_if: transformed vector channel
`default_nettype none

interface vt4_out_if;
	logic                       valid;
	logic                       ready;
	logic signed [vt4_pkg::VEC_BITS-1:0] out_x;
	logic signed [vt4_pkg::VEC_BITS-1:0] out_y;
	logic signed [vt4_pkg::VEC_BITS-1:0] out_z;
	logic signed [vt4_pkg::VEC_BITS-1:0] out_w;

	modport source (output valid, output out_x, output out_y, output out_z, output out_w,
		input ready);
	modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
		output ready);
endinterface

`default_nettype wire

FILE: sv/vt4_cfg_if.sv
// vt4_cfg_if: matrix register write channel
`default_nettype none

interface vt4_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [vt4_pkg::CFG_IDX_BITS-1:0]  index;
	logic [vt4_pkg::CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/vertex_transform_4x4_top.sv
// vertex_transform_4x4_top: pipelined 4x4 matrix times vector in signed Q16.16
//
//   channel   dir  handshake        payload
//   in_vec    in   valid/ready      in_x, in_y, in_z, in_w
//   out_vec   out  valid/ready      out_x, out_y, out_z, out_w
//   cfg       in   valid/ready      index, data (ready always high)
//
// one vector per cycle while the output is not stalled; each request moves through the stages below in order
// stages: input reg, 16 multipliers, pair sums, row sums, round/saturate output reg
// arst_n clears all valid bits and loads the identity matrix
// each stage holds while the stage after it is full and stalled; bubbles close up
`default_nettype none

module vertex_transform_4x4_top #(
	parameter int WORD_BITS = vt4_pkg::WORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	vt4_in_if.sink    in_vec,
	vt4_out_if.source out_vec,
	vt4_cfg_if.sink   cfg
);
	import vt4_pkg::*;

	localparam int PROD_BITS = VEC_BITS + WORD_BITS;
	localparam int SUM2_BITS = PROD_BITS + 1;
	localparam int SUM4_BITS = PROD_BITS + 2;
	localparam int Q_BITS    = SUM4_BITS - FRAC_BITS;
	localparam longint SAT_MAX_L = (longint'(1) <<< (WORD_BITS - 1)) - 1;
	localparam longint SAT_MIN_L = -SAT_MAX_L - 1;
	localparam logic signed [Q_BITS-1:0] SAT_MAX = Q_BITS'(SAT_MAX_L);
	localparam logic signed [Q_BITS-1:0] SAT_MIN = Q_BITS'(SAT_MIN_L);

	// matrix registers
	cfg_word_t cfg_q [NUM_REGS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg.valid && cfg.ready && (cfg.index < CFG_IDX_BITS'(NUM_REGS))) begin
			cfg_q[cfg.index[CFG_SEL_BITS-1:0]] <= cfg.data;
		end
	end

	// entries [row][col], low WORD_BITS bits of each half
	logic signed [WORD_BITS-1:0] ent [NUM_COMP][NUM_COMP];

	for (genvar r = 0; r < NUM_COMP; r++) begin : g_row
		for (genvar c = 0; c < NUM_COMP; c++) begin : g_col
			assign ent[r][c] = cfg_q[c * 2 + r / 2][(r % 2) * HALF_BITS +: WORD_BITS];
		end
	end

	// pipeline registers
	logic                        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	vec_word_t                   vec_s1  [NUM_COMP];
	logic signed [PROD_BITS-1:0] prod_s2 [NUM_COMP][NUM_COMP];
	logic signed [SUM2_BITS-1:0] pair_s3 [NUM_COMP][2];
	logic signed [SUM4_BITS-1:0] sum_s4  [NUM_COMP];
	vec_word_t                   res_s5  [NUM_COMP];

	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !valid_s5 || out_vec.ready;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign in_vec.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_vec.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: capture request
	always_ff @(posedge clk) begin
		if (rdy1 && in_vec.valid) begin
			vec_s1[0] <= in_vec.in_x;
			vec_s1[1] <= in_vec.in_y;
			vec_s1[2] <= in_vec.in_z;
			vec_s1[3] <= in_vec.in_w;
		end
	end

	// stage 2: sixteen products
	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			for (int r = 0; r < NUM_COMP; r++) begin
				for (int c = 0; c < NUM_COMP; c++) begin
					prod_s2[r][c] <= PROD_BITS'(vec_s1[c]) * PROD_BITS'(ent[r][c]);
				end
			end
		end
	end

	// stage 3: pair sums
	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			for (int r = 0; r < NUM_COMP; r++) begin
				pair_s3[r][0] <= SUM2_BITS'(prod_s2[r][0]) + SUM2_BITS'(prod_s2[r][1]);
				pair_s3[r][1] <= SUM2_BITS'(prod_s2[r][2]) + SUM2_BITS'(prod_s2[r][3]);
			end
		end
	end

	// stage 4: row sums
	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			for (int r = 0; r < NUM_COMP; r++) begin
				sum_s4[r] <= SUM4_BITS'(pair_s3[r][0]) + SUM4_BITS'(pair_s3[r][1]);
			end
		end
	end

	// stage 5: truncate toward zero, saturate to WORD_BITS, sign-extend
	logic signed [SUM4_BITS-1:0] biased [NUM_COMP];
	logic signed [Q_BITS-1:0]    q_val  [NUM_COMP];
	logic signed [WORD_BITS-1:0] sat    [NUM_COMP];

	always_comb begin
		for (int r = 0; r < NUM_COMP; r++) begin
			// negative sums get 2^16-1 added so the shift rounds toward zero
			biased[r] = sum_s4[r] + $signed({{(SUM4_BITS - FRAC_BITS){1'b0}},
				{FRAC_BITS{sum_s4[r][SUM4_BITS-1]}}});
			q_val[r] = $signed(biased[r][SUM4_BITS-1:FRAC_BITS]);
			if (q_val[r] > SAT_MAX) begin
				sat[r] = WORD_BITS'(SAT_MAX);
			end else if (q_val[r] < SAT_MIN) begin
				sat[r] = WORD_BITS'(SAT_MIN);
			end else begin
				sat[r] = WORD_BITS'(q_val[r]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && valid_s4) begin
			for (int r = 0; r < NUM_COMP; r++) begin
				res_s5[r] <= VEC_BITS'(sat[r]);
			end
		end
	end

	assign out_vec.valid = valid_s5;
	assign out_vec.out_x = res_s5[0];
	assign out_vec.out_y = res_s5[1];
	assign out_vec.out_z = res_s5[2];
	assign out_vec.out_w = res_s5[3];

endmodule

`default_nettype wire

FILE: tb/sv/vertex_transform_4x4_checker.sv
// vertex_transform_4x4_checker: predicts each transformed vertex and compares it with the result channel
`default_nettype none

module vertex_transform_4x4_checker #(
	parameter int WORD_BITS = vt4_pkg::WORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	vt4_in_if    in_vec,
	vt4_out_if   out_vec,
	vt4_cfg_if   cfg,
	output int   errors,
	output int   pending
);

	import vt4_pkg::*;

	typedef struct packed {
		vec_word_t x;
		vec_word_t y;
		vec_word_t z;
		vec_word_t w;
	} vertex_t;

	typedef logic signed [127:0] wide_t;

	cfg_regs_t matrix;
	vertex_t   expected_vertices [$];
	string     field_names [NUM_COMP] = '{"out_x", "out_y", "out_z", "out_w"};

	// one output row: exact sum of four products, truncate toward zero, saturate
	function automatic vec_word_t row_dot(input cfg_regs_t m, input int row, input vertex_t v);
		logic [HALF_BITS-1:0] half;
		vec_word_t comp [NUM_COMP];
		vec_word_t coef;
		wide_t acc, a, b, mag, lim_hi, lim_lo;
		logic neg;
		comp[0] = v.x;
		comp[1] = v.y;
		comp[2] = v.z;
		comp[3] = v.w;
		acc = '0;
		for (int c = 0; c < NUM_COMP; c++) begin
			if (row[0])
				half = m[2 * c + row / 2][CFG_DATA_BITS-1:HALF_BITS];
			else
				half = m[2 * c + row / 2][HALF_BITS-1:0];
			// keep only the low WORD_BITS bits, sign-extended
			coef = $signed(half << (VEC_BITS - WORD_BITS)) >>> (VEC_BITS - WORD_BITS);
			a = comp[c];
			b = coef;
			acc = acc + a * b;
		end
		neg = acc[127];
		mag = neg ? -acc : acc;
		mag = mag >>> FRAC_BITS;
		if (neg)
			mag = -mag;
		lim_hi = 1;
		lim_hi = (lim_hi <<< (WORD_BITS - 1)) - 1;
		lim_lo = -lim_hi - 1;
		if (mag > lim_hi)
			mag = lim_hi;
		else if (mag < lim_lo)
			mag = lim_lo;
		return mag[VEC_BITS-1:0];
	endfunction

	function automatic vertex_t transform_vertex(input cfg_regs_t m, input vertex_t v);
		vertex_t r;
		r.x = row_dot(m, 0, v);
		r.y = row_dot(m, 1, v);
		r.z = row_dot(m, 2, v);
		r.w = row_dot(m, 3, v);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vertex_t got;
		vertex_t want;
		if (!arst_n) begin
			matrix = CFG_RESET;
			expected_vertices.delete();
			errors = 0;
		end else begin
			if (cfg.valid && cfg.ready && cfg.index < NUM_REGS)
				matrix[cfg.index] = cfg.data;
			if (in_vec.valid && in_vec.ready)
				expected_vertices.push_back(transform_vertex(matrix,
					{in_vec.in_x, in_vec.in_y, in_vec.in_z, in_vec.in_w}));
			if (out_vec.valid && out_vec.ready) begin
				got = {out_vec.out_x, out_vec.out_y, out_vec.out_z, out_vec.out_w};
				if (expected_vertices.size() == 0) begin
					$error("unexpected result: no request pending");
					errors++;
				end else begin
					want = expected_vertices.pop_front();
					for (int i = 0; i < NUM_COMP; i++) begin
						if (got[(NUM_COMP-1-i)*VEC_BITS +: VEC_BITS] !==
							want[(NUM_COMP-1-i)*VEC_BITS +: VEC_BITS]) begin
							$error("%s: expected %0d, actual %0d", field_names[i],
								$signed(want[(NUM_COMP-1-i)*VEC_BITS +: VEC_BITS]),
								$signed(got[(NUM_COMP-1-i)*VEC_BITS +: VEC_BITS]));
							errors++;
						end
					end
				end
			end
		end
		pending = expected_vertices.size();
	end

endmodule

`default_nettype wire

FILE: tb/sv/vertex_transform_4x4_top_test.sv
// vertex_transform_4x4_top_test: stimulus, receiver back-pressure and verdict for the vertex transform
`default_nettype none

module vertex_transform_4x4_top_test;

	import vt4_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 240;
	localparam int IDLE_PCT      = 17;
	localparam int RESET_CYCLES  = 12;
	localparam int TAIL_CYCLES   = 10;

	localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_NONE_LO = CFG_IDX_BITS'(NUM_REGS);
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_NONE_HI = '1;

	localparam vec_word_t Q_MAX  = 32'h7fff_ffff;
	localparam vec_word_t Q_MIN  = 32'h8000_0000;
	localparam vec_word_t Q_ONE  = 32'h0001_0000;
	localparam vec_word_t Q_HALF = 32'h0000_8000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   quiet = 0;
	bit   no_idle;
	bit   hold_req;

	vt4_in_if  in_vec ();
	vt4_out_if out_vec ();
	vt4_cfg_if cfg ();

	vertex_transform_4x4_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vec  (in_vec),
		.out_vec (out_vec),
		.cfg     (cfg)
	);

	vertex_transform_4x4_checker #(
		.WORD_BITS (WORD_BITS_DEF)
	) checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vec  (in_vec),
		.out_vec (out_vec),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_vec.valid && in_vec.ready) || (out_vec.valid && out_vec.ready) ||
			(cfg.valid && cfg.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// receiver side: random stalls, one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_vec.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_vec.ready <= 1'b0;
				hold_left--;
			end else begin
				out_vec.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	function automatic vec_word_t rand_q16();
		case ($urandom_range(3))
			0, 1: return $urandom;
			2: return $urandom_range(0, 20'hf_ffff) - 20'h8_0000;
			default: begin
				case ($urandom_range(4))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					3: return Q_ONE;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	task automatic send_vertex(input vec_word_t x, input vec_word_t y, input vec_word_t z,
		input vec_word_t w);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_vec.valid <= 1'b0;
			@(posedge clk);
		end
		in_vec.valid <= 1'b1;
		in_vec.in_x  <= x;
		in_vec.in_y  <= y;
		in_vec.in_z  <= z;
		in_vec.in_w  <= w;
		do @(posedge clk); while (!in_vec.ready);
	endtask

	task automatic send_random();
		send_vertex(rand_q16(), rand_q16(), rand_q16(), rand_q16());
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input cfg_word_t word);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= word;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// all eight registers, then one write to an index past the list that must be ignored
	task automatic load_matrix(input cfg_regs_t m);
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(i[CFG_IDX_BITS-1:0], m[i]);
		write_reg($urandom_range(1) ? CFG_IDX_NONE_HI : CFG_IDX_NONE_LO, {$urandom, $urandom});
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		in_vec.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		cfg_regs_t m;
		arst_n       <= 1'b0;
		in_vec.valid <= 1'b0;
		in_vec.in_x  <= '0;
		in_vec.in_y  <= '0;
		in_vec.in_z  <= '0;
		in_vec.in_w  <= '0;
		cfg.valid    <= 1'b0;
		cfg.index    <= '0;
		cfg.data     <= '0;
		no_idle  = 1'b0;
		hold_req = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset
		send_vertex('0, '0, '0, '0);
		send_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_vertex(Q_ONE, -Q_ONE, Q_MAX, Q_MIN);
		send_random();
		send_random();
		drain();

		// largest entries: positive and negative overflow
		foreach (m[i]) m[i] = {Q_MAX, Q_MAX};
		load_matrix(m);
		send_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_vertex(1, -1, 0, 0);
		send_vertex(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
		drain();

		// most negative entries: sum of four products beyond 64 bits
		foreach (m[i]) m[i] = {Q_MIN, Q_MIN};
		load_matrix(m);
		send_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_vertex(Q_MIN, Q_MAX, 0, 0);
		drain();

		// half entries: truncation toward zero for negative sums
		foreach (m[i]) m[i] = {Q_HALF, Q_HALF};
		load_matrix(m);
		send_vertex(-1, 0, 0, 0);
		send_vertex(1, 0, 0, 0);
		send_vertex(-3, 0, 0, 0);
		send_vertex(3, 0, 0, 0);
		send_vertex(-1, -1, -1, 0);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			foreach (m[i]) m[i] = {rand_q16(), rand_q16()};
			load_matrix(m);
			if (p == 0)
				hold_req = 1'b1;
			no_idle = (p == 2);
			repeat (PHASE_ITEMS) send_random();
			drain();
			no_idle = 1'b0;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
